// ===== rtl/ece_pkg.sv =====
// ----------------------------------------------------------------------------
// ece_pkg
// Shared types, constants and fixed-point helpers for the easing curve
// evaluator.
// ----------------------------------------------------------------------------
package ece_pkg;

  localparam int FRAC_BITS = 16;
  localparam int U_W       = FRAC_BITS + 1;
  localparam int QW        = 40;
  localparam int MW        = 34;

  typedef logic signed [QW-1:0] q_t;

  localparam q_t ONE_Q   = q_t'(64'sd1 <<< 30);
  localparam q_t TWO_Q   = q_t'(64'sd2 <<< 30);
  localparam q_t B_LIM1  = q_t'(64'sd4 <<< 30);
  localparam q_t B_LIM2  = q_t'(64'sd8 <<< 30);
  localparam q_t B_LIM3  = q_t'(64'sd10 <<< 30);
  localparam q_t B_OFF1  = q_t'(((64'sd6 <<< 30) + 64'sd5) / 64'sd11);
  localparam q_t B_OFF2  = q_t'(((64'sd9 <<< 30) + 64'sd5) / 64'sd11);
  localparam q_t B_OFF3  = q_t'(((64'sd21 <<< 30) + 64'sd11) / 64'sd22);
  localparam q_t B_ADD1  = q_t'(64'sd3 <<< 28);
  localparam q_t B_ADD2  = q_t'(64'sd15 <<< 26);
  localparam q_t B_ADD3  = q_t'(64'sd63 <<< 24);

  typedef enum logic [1:0] {K_LIN, K_POLY, K_BACK, K_BOUNCE} kind_t;
  typedef enum logic [1:0] {F_IN, F_OUT, F_INOUT} form_t;

  typedef struct packed {
    logic [4:0]         sel;
    logic signed [15:0] start;
    logic signed [16:0] chg;
    logic [15:0]        dur;
    logic [15:0]        bo;
  } cfg_t;

  // Rounded product, half away from zero; shift 31 when half is set, else 30.
  // Operand magnitudes stay below 2^34.
  function automatic q_t mulsh(input q_t a, input q_t b, input logic half);
    logic [MW-1:0]   ma;
    logic [MW-1:0]   mb;
    logic [2*MW-1:0] p;
    logic [2*MW-1:0] m;
    logic            neg;
    neg = a[QW-1] ^ b[QW-1];
    ma  = a[QW-1] ? MW'(~a + q_t'(1)) : MW'(a);
    mb  = b[QW-1] ? MW'(~b + q_t'(1)) : MW'(b);
    p   = (2*MW)'(ma) * (2*MW)'(mb);
    if (half) begin
      m = (p + ((2*MW)'(1) << 30)) >> 31;
    end else begin
      m = (p + ((2*MW)'(1) << 29)) >> 30;
    end
    mulsh = neg ? -q_t'(m[QW-1:0]) : q_t'(m[QW-1:0]);
  endfunction

endpackage

// ===== rtl/ece_div.sv =====
// ----------------------------------------------------------------------------
// ece_div
// Clamps elapsed to the duration and forms u = t * 2^FRAC_BITS / duration,
// one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module ece_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [15:0]             elapsed,
  input  logic [15:0]             duration,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ece_pkg::U_W-1:0] u,
  output logic                    sat
);
  import ece_pkg::*;

  localparam int NS = U_W + 1;

  logic [NS-1:0]  v;
  logic [NS-1:0]  en;
  logic [16:0]    rem      [NS];
  logic [16:0]    rem_next [NS];
  logic [16:0]    shl      [NS];
  logic [NS-1:0]  ge;
  logic [U_W-1:0] quo      [NS];
  logic [U_W-1:0] quo_next [NS];
  logic [NS-1:0]  st;
  logic [15:0]    dur;
  logic           over;

  assign dur  = (duration == 16'd0) ? 16'd1 : duration;
  assign over = elapsed > dur;

  always_comb begin
    en[NS-1] = !v[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_comb begin
    shl[0]      = '0;
    ge[0]       = 1'b0;
    rem_next[0] = over ? {1'b0, dur} : {1'b0, elapsed};
    quo_next[0] = '0;
    for (int i = 1; i < NS; i++) begin
      shl[i]      = (i == 1) ? rem[i-1] : {rem[i-1][15:0], 1'b0};
      ge[i]       = shl[i] >= {1'b0, dur};
      rem_next[i] = ge[i] ? shl[i] - {1'b0, dur} : shl[i];
      quo_next[i] = {quo[i-1][U_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= rem_next[0];
      quo[0] <= quo_next[0];
      st[0]  <= over;
    end
    for (int i = 1; i < NS; i++) begin
      if (en[i]) begin
        rem[i] <= rem_next[i];
        quo[i] <= quo_next[i];
        st[i]  <= st[i-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NS-1];
  assign u         = quo[NS-1];
  assign sat       = st[NS-1];

  a_u_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (u <= (U_W'(1) << FRAC_BITS)))
    else $error("quotient above one");

endmodule

// ===== rtl/ece_curve.sv =====
// ----------------------------------------------------------------------------
// ece_curve
// Evaluates the selected easing curve on u in Q30 over six stages:
// operand prep, four multiply stages and the final combine.
// ----------------------------------------------------------------------------
module ece_curve (
  input  logic                    clk,
  input  logic                    rst,
  input  ece_pkg::cfg_t           cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ece_pkg::U_W-1:0] u,
  input  logic                    in_sat,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ece_pkg::q_t             f,
  output logic                    out_sat
);
  import ece_pkg::*;

  localparam int NST = 6;

  typedef struct packed {
    kind_t      kind;
    form_t      form;
    logic [2:0] pw;
    logic       lo;
    logic       sat;
    q_t         x;
    q_t         x2;
    q_t         m2;
    q_t         m3;
    q_t         m4;
    q_t         add;
    q_t         f;
  } item_t;

  logic [NST-1:0] v;
  logic [NST-1:0] en;
  item_t          st  [NST];
  item_t          nxt [NST];

  kind_t          kind;
  form_t          form;
  logic [2:0]     pw;
  logic [4:0]     fi;

  logic [21:0]    b61;
  logic [22:0]    n5;
  logic [46:0]    p5;
  q_t             s2;
  q_t             s;
  q_t             s3;

  assign s  = q_t'(cfg.bo) <<< 16;
  assign s3 = s + ONE_Q;
  assign n5 = {b61, 1'b0} + 23'd2;
  assign p5 = 47'(n5) * 47'd13421773;

  // s2 = round(overshoot * 1.525 * 2^16), from a reciprocal of five
  always_ff @(posedge clk) begin
    b61 <= 22'(cfg.bo) * 22'd61;
    s2  <= q_t'(33'(b61) * 33'd1638 + 33'(p5[46:26]));
  end

  always_comb begin
    kind = K_LIN;
    pw   = 3'd2;
    fi   = 5'd0;
    case (cfg.sel) inside
      [5'd1:5'd3]: begin
        kind = K_POLY; pw = 3'd2; fi = cfg.sel - 5'd1;
      end
      [5'd4:5'd6]: begin
        kind = K_POLY; pw = 3'd3; fi = cfg.sel - 5'd4;
      end
      [5'd7:5'd9]: begin
        kind = K_POLY; pw = 3'd4; fi = cfg.sel - 5'd7;
      end
      [5'd10:5'd12]: begin
        kind = K_POLY; pw = 3'd5; fi = cfg.sel - 5'd10;
      end
      [5'd13:5'd15]: begin
        kind = K_BACK; fi = cfg.sel - 5'd13;
      end
      [5'd16:5'd18]: begin
        kind = K_BOUNCE; fi = cfg.sel - 5'd16;
      end
      default: begin
        kind = K_LIN;
      end
    endcase
    form = form_t'(fi[1:0]);
  end

  always_comb begin
    en[NST-1] = !v[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_comb begin
    q_t uq;
    q_t u2;
    q_t xb;
    q_t p;
    q_t b;
    uq = q_t'(u) <<< (30 - FRAC_BITS);
    u2 = uq <<< 1;
    xb = '0;
    p  = '0;
    b  = '0;

    // operand prep
    nxt[0]      = '0;
    nxt[0].kind = kind;
    nxt[0].form = form;
    nxt[0].pw   = pw;
    nxt[0].lo   = u2 < ONE_Q;
    nxt[0].sat  = in_sat;
    nxt[0].x    = uq;
    case (kind)
      K_POLY: begin
        case (form)
          F_IN:    nxt[0].x = uq;
          F_OUT:   nxt[0].x = ONE_Q - uq;
          default: nxt[0].x = (u2 < ONE_Q) ? uq : ONE_Q - uq;
        endcase
      end
      K_BACK: begin
        case (form)
          F_IN:    nxt[0].x = uq;
          F_OUT:   nxt[0].x = uq - ONE_Q;
          default: nxt[0].x = (u2 < ONE_Q) ? u2 : u2 - TWO_Q;
        endcase
      end
      K_BOUNCE: begin
        case (form)
          F_IN:    xb = ONE_Q - uq;
          F_OUT:   xb = uq;
          default: xb = (u2 < ONE_Q) ? ONE_Q - u2 : u2 - ONE_Q;
        endcase
        if (xb * q_t'(11) < B_LIM1) begin
          nxt[0].x = xb;          nxt[0].add = '0;
        end else if (xb * q_t'(11) < B_LIM2) begin
          nxt[0].x = xb - B_OFF1; nxt[0].add = B_ADD1;
        end else if (xb * q_t'(11) < B_LIM3) begin
          nxt[0].x = xb - B_OFF2; nxt[0].add = B_ADD2;
        end else begin
          nxt[0].x = xb - B_OFF3; nxt[0].add = B_ADD3;
        end
      end
      default: nxt[0].x = uq;
    endcase

    // square
    nxt[1]    = st[0];
    nxt[1].x2 = mulsh(st[0].x, st[0].x, 1'b0);

    // cube, slope term or bounce scale
    nxt[2] = st[1];
    case (st[1].kind)
      K_BACK: begin
        if (st[1].form == F_INOUT) begin
          nxt[2].m2 = mulsh(s2 + ONE_Q, st[1].x, 1'b0);
        end else begin
          nxt[2].m2 = mulsh(st[1].x2, st[1].x, 1'b0);
        end
      end
      K_BOUNCE: nxt[2].m2 = (st[1].x2 * q_t'(121) + q_t'(8)) >>> 4;
      default:  nxt[2].m2 = mulsh(st[1].x2, st[1].x, 1'b0);
    endcase

    // fourth power or back term
    nxt[3] = st[2];
    case (st[2].kind)
      K_BACK: begin
        if (st[2].form == F_INOUT) begin
          nxt[3].m3 = mulsh(st[2].x2, st[2].lo ? st[2].m2 - s2 : st[2].m2 + s2, 1'b1);
        end else begin
          nxt[3].m3 = mulsh(s3, st[2].m2, 1'b0);
        end
      end
      default: nxt[3].m3 = mulsh(st[2].m2, st[2].x, 1'b0);
    endcase

    // fifth power or back square term
    nxt[4] = st[3];
    case (st[3].kind)
      K_BACK:  nxt[4].m4 = mulsh(s, st[3].x2, 1'b0);
      default: nxt[4].m4 = mulsh(st[3].m3, st[3].x, 1'b0);
    endcase

    // combine
    nxt[5] = st[4];
    case (st[4].pw)
      3'd2:    p = st[4].x2;
      3'd3:    p = st[4].m2;
      3'd4:    p = st[4].m3;
      default: p = st[4].m4;
    endcase
    b = st[4].m2 + st[4].add;
    case (st[4].kind)
      K_POLY: begin
        case (st[4].form)
          F_IN:    nxt[5].f = p;
          F_OUT:   nxt[5].f = ONE_Q - p;
          default: nxt[5].f = st[4].lo ? p <<< (st[4].pw - 3'd1)
                                       : ONE_Q - (p <<< (st[4].pw - 3'd1));
        endcase
      end
      K_BACK: begin
        case (st[4].form)
          F_IN:    nxt[5].f = st[4].m3 - st[4].m4;
          F_OUT:   nxt[5].f = ONE_Q + st[4].m3 + st[4].m4;
          default: nxt[5].f = st[4].lo ? st[4].m3 : st[4].m3 + ONE_Q;
        endcase
      end
      K_BOUNCE: begin
        case (st[4].form)
          F_IN:    nxt[5].f = ONE_Q - b;
          F_OUT:   nxt[5].f = b;
          default: nxt[5].f = st[4].lo ? (ONE_Q - b + q_t'(1)) >>> 1
                                       : (ONE_Q + b + q_t'(1)) >>> 1;
        endcase
      end
      default: nxt[5].f = st[4].x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NST; i++) begin
      if (en[i]) st[i] <= nxt[i];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];
  assign f         = st[NST-1].f;
  assign out_sat   = st[NST-1].sat;

  a_poly_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && st[NST-1].kind == K_POLY) |-> (f >= q_t'(0) && f <= ONE_Q))
    else $error("polynomial curve outside unit range");

endmodule

// ===== rtl/ece_scale.sv =====
// ----------------------------------------------------------------------------
// ece_scale
// Scales the curve value by change, adds start and saturates to 18 bits;
// the last stage is the output register.
// ----------------------------------------------------------------------------
module ece_scale (
  input  logic               clk,
  input  logic               rst,
  input  ece_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  ece_pkg::q_t        f,
  input  logic               in_sat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [17:0] eased_value,
  output logic               saturated
);
  import ece_pkg::*;

  localparam q_t MAX_V = q_t'(131071);
  localparam q_t MIN_V = -q_t'(131072);

  logic en_a;
  logic en_o;
  logic a_v;
  q_t   a_prod;
  logic a_sat;
  q_t   sum;

  assign en_o = !out_valid || out_ready;
  assign en_a = !a_v || en_o;
  assign sum  = q_t'(cfg.start) + a_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) a_v <= in_valid;
      if (en_o) out_valid <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_prod <= mulsh(q_t'(cfg.chg), f, 1'b0);
      a_sat  <= in_sat;
    end
    if (en_o) begin
      if (sum > MAX_V) begin
        eased_value <= 18'sh1FFFF;
        saturated   <= 1'b1;
      end else if (sum < MIN_V) begin
        eased_value <= 18'sh20000;
        saturated   <= 1'b1;
      end else begin
        eased_value <= sum[17:0];
        saturated   <= a_sat;
      end
    end
  end

  assign in_ready = en_a;

endmodule

// ===== rtl/easing_curve_evaluator.sv =====
// ----------------------------------------------------------------------------
// easing_curve_evaluator
// Penner easing curves in fixed point: start + change * curve(t / duration).
// ----------------------------------------------------------------------------
// Accepts one elapsed count per clock unless a stalled output has filled the
// pipeline, and returns one eased value per request after the clamp and the
// one-bit-per-stage restoring division, curve evaluation (prep, four multiply
// stages, combine), and scaling and saturation. Empty stages are filled while the output stalls.
// Write configuration only while no request is in flight.
module easing_curve_evaluator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] elapsed
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [17:0] eased_value, [23:18] zero
  output logic        m_tuser,   // [0] saturated
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  import ece_pkg::*;

  typedef enum logic [2:0] {
    REG_CURVE     = 3'd0,
    REG_START     = 3'd1,
    REG_CHANGE    = 3'd2,
    REG_DURATION  = 3'd3,
    REG_OVERSHOOT = 3'd4
  } reg_idx_t;

  cfg_t               cfg;
  logic               d_valid;
  logic               d_ready;
  logic [U_W-1:0]     d_u;
  logic               d_sat;
  logic               c_valid;
  logic               c_ready;
  q_t                 c_f;
  logic               c_sat;
  logic signed [17:0] eased_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sel   <= 5'd0;
      cfg.start <= 16'sd0;
      cfg.chg   <= 17'sd0;
      cfg.dur   <= 16'd1;
      cfg.bo    <= 16'd27879;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CURVE:     cfg.sel   <= cfg_data[4:0];
        REG_START:     cfg.start <= cfg_data[15:0];
        REG_CHANGE:    cfg.chg   <= cfg_data;
        REG_DURATION:  cfg.dur   <= cfg_data[15:0];
        REG_OVERSHOOT: cfg.bo    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ece_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .elapsed   (s_tdata),
    .duration  (cfg.dur),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .u         (d_u),
    .sat       (d_sat)
  );

  ece_curve u_curve (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .u         (d_u),
    .in_sat    (d_sat),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .f         (c_f),
    .out_sat   (c_sat)
  );

  ece_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (c_valid),
    .in_ready    (c_ready),
    .f           (c_f),
    .in_sat      (c_sat),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .eased_value (eased_value),
    .saturated   (m_tuser)
  );

  assign m_tdata = {6'd0, eased_value};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_chain_ready: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> (c_ready && d_ready && s_tready))
    else $error("pipeline stalled while output drains");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:18] == 6'd0))
    else $error("tdata padding not zero");

endmodule
